/* hdl/hsfc_pkg.sv */
// Shared types, register indexes and flag positions for the Hall sensor frame checker.
package hsfc_pkg;

	localparam int FRAME_W = 56;
	localparam int RESULT_W = 72;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_NEGATE_X = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NEGATE_Y = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NEGATE_Z = 2'd2;

	localparam int FLAG_READ_FAIL  = 0;
	localparam int FLAG_BUS_PARITY = 1;
	localparam int FLAG_PD0        = 2;
	localparam int FLAG_PD3        = 3;
	localparam int FLAG_TESTMODE   = 4;
	localparam int FLAG_CFG_PARITY = 5;
	localparam int FLAG_FUSE       = 6;
	localparam int FLAG_FRAME_REPT = 7;

	localparam int DIAG_P    = 7;
	localparam int DIAG_FF   = 6;
	localparam int DIAG_CF   = 5;
	localparam int DIAG_T    = 4;
	localparam int DIAG_PD3  = 3;
	localparam int DIAG_PD0  = 2;

	localparam logic [15:0] NEG_LIMIT = 16'h8000;
	localparam logic [15:0] POS_LIMIT = 16'h7FFF;

	// Register bytes of one frame; the first register sits in the lowest bits.
	typedef struct packed {
		logic [7:0] diag_byte;
		logic [7:0] temp_z_low_bits;
		logic [7:0] xy_low_nibbles;
		logic [7:0] temp_high_byte;
		logic [7:0] z_high_byte;
		logic [7:0] y_high_byte;
		logic [7:0] x_high_byte;
	} frame_t;

	typedef struct packed {
		logic negate_z;
		logic negate_y;
		logic negate_x;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  frame_count;
		logic [15:0] temp_value;
		logic [15:0] z_value;
		logic [15:0] y_value;
		logic [15:0] x_value;
	} held_t;

	typedef struct packed {
		logic        values_updated;
		held_t       held;
		logic [7:0]  error_flags;
	} result_t;

	function automatic logic [15:0] neg_sat(input logic [15:0] raw, input logic enable);
		logic [15:0] res;
		res = raw;
		if (enable) begin
			if (raw == NEG_LIMIT) begin
				res = POS_LIMIT;
			end else begin
				res = (~raw) + 16'd1;
			end
		end
		return res;
	endfunction

endpackage

/* hdl/hsfc_decode.sv */
// Frame check and value assembly logic for one sensor readout frame.
module hsfc_decode (
	input  logic            read_ok,
	input  hsfc_pkg::frame_t frame,
	input  hsfc_pkg::cfg_t  cfg,
	input  hsfc_pkg::held_t held,
	output hsfc_pkg::result_t res
);

	logic       parity;
	logic [7:0] diag_flags;
	logic [1:0] frm;
	logic [15:0] raw_x;
	logic [15:0] raw_y;
	logic [15:0] raw_z;

	assign parity = ^{frame.x_high_byte, frame.y_high_byte, frame.z_high_byte,
		frame.temp_high_byte, frame.xy_low_nibbles, frame.temp_z_low_bits};
	assign frm = frame.diag_byte[1:0];

	assign raw_x = {frame.x_high_byte, frame.xy_low_nibbles[7:4], 4'h0};
	assign raw_y = {frame.y_high_byte, frame.xy_low_nibbles[3:0], 4'h0};
	assign raw_z = {frame.z_high_byte, frame.temp_z_low_bits[3:0], 4'h0};

	always_comb begin
		diag_flags = 8'h00;
		diag_flags[hsfc_pkg::FLAG_BUS_PARITY] = (frame.diag_byte[hsfc_pkg::DIAG_P] == parity);
		diag_flags[hsfc_pkg::FLAG_PD0] = !frame.diag_byte[hsfc_pkg::DIAG_PD0];
		diag_flags[hsfc_pkg::FLAG_PD3] = !frame.diag_byte[hsfc_pkg::DIAG_PD3];
		diag_flags[hsfc_pkg::FLAG_TESTMODE] = frame.diag_byte[hsfc_pkg::DIAG_T];
		diag_flags[hsfc_pkg::FLAG_CFG_PARITY] = !frame.diag_byte[hsfc_pkg::DIAG_CF];
		diag_flags[hsfc_pkg::FLAG_FUSE] = !frame.diag_byte[hsfc_pkg::DIAG_FF];
	end

	always_comb begin
		res.held = held;
		res.values_updated = 1'b0;
		res.error_flags = 8'h00;
		if (!read_ok) begin
			res.error_flags[hsfc_pkg::FLAG_READ_FAIL] = 1'b1;
		end else if (diag_flags != 8'h00) begin
			res.error_flags = diag_flags;
		end else begin
			res.values_updated = 1'b1;
			res.held.x_value = hsfc_pkg::neg_sat(raw_x, cfg.negate_x);
			res.held.y_value = hsfc_pkg::neg_sat(raw_y, cfg.negate_y);
			res.held.z_value = hsfc_pkg::neg_sat(raw_z, cfg.negate_z);
			res.held.temp_value = {frame.temp_high_byte, frame.temp_z_low_bits[7:6], 6'h00};
			if (frm == held.frame_count) begin
				res.error_flags[hsfc_pkg::FLAG_FRAME_REPT] = 1'b1;
			end else begin
				res.held.frame_count = frm;
			end
		end
	end

endmodule

/* hdl/hall_sensor_frame_checker_core.sv */
// Top level of the Hall sensor readout frame checker.
//
// One item on the input stream is one sensor readout frame: tdata carries the
// seven register bytes and tuser carries the bus read-ok flag. Every frame
// yields exactly one result item with the error flags and the held X, Y, Z and
// temperature values; tuser of the result says whether this frame updated them.
// The negate registers are written through the plain write port; the user
// must write them only while idle, as the block itself does not enforce it.
// An accepted item is registered in the input stage and its result is loaded
// into the output register once that register is empty or its item is taken.
// Throughput is one item per cycle unless the receiver stalls, set by the
// single combinational check stage between the input and output registers.
// When the receiver stalls, the output register holds its item and the input
// register still takes one more item; input ready drops only when both are
// full. Reset empties both stages and clears the held values, the stored frame
// counter and the negate registers.
module hall_sensor_frame_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// x_high_byte, y_high_byte, z_high_byte, temp_high_byte, xy_low_nibbles,
	// temp_z_low_bits, diag_byte
	input  logic [hsfc_pkg::FRAME_W-1:0] s_axis_tdata,
	// read_ok
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// error_flags, x_value, y_value, z_value, temp_value
	output logic [hsfc_pkg::RESULT_W-1:0] m_axis_tdata,
	// values_updated
	output logic        m_axis_tuser,
	input  logic        cfg_we,
	input  logic [hsfc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic        cfg_data
);

	logic              valid_s1;
	hsfc_pkg::frame_t  frame_s1;
	logic              read_ok_s1;
	logic              valid_s2;
	hsfc_pkg::result_t result_s2;
	hsfc_pkg::held_t   held_q;
	hsfc_pkg::cfg_t    cfg_q;
	hsfc_pkg::result_t result;
	logic              out_free;

	assign out_free = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				hsfc_pkg::REG_NEGATE_X: cfg_q.negate_x <= cfg_data;
				hsfc_pkg::REG_NEGATE_Y: cfg_q.negate_y <= cfg_data;
				hsfc_pkg::REG_NEGATE_Z: cfg_q.negate_z <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			frame_s1 <= hsfc_pkg::frame_t'(s_axis_tdata);
			read_ok_s1 <= s_axis_tuser;
		end
	end

	hsfc_decode u_decode (
		.read_ok (read_ok_s1),
		.frame   (frame_s1),
		.cfg     (cfg_q),
		.held    (held_q),
		.res     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			held_q <= '0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				held_q <= result.held;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {result_s2.held.temp_value, result_s2.held.z_value,
		result_s2.held.y_value, result_s2.held.x_value, result_s2.error_flags};
	assign m_axis_tuser = result_s2.values_updated;

endmodule

/* hdl/hsfc_checker.sv */
// Port-level assertions for the Hall sensor frame checker and their binding.
module hsfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	a_update_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[6:0] == 7'h00)
		else $error("values updated despite a frame error");

	a_repeat_needs_update: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[7])
		else $error("frame repeat flagged without an update");

	a_read_fail_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[7:1] == 7'h00 && !m_axis_tuser)
		else $error("read failure reported with other flags");

endmodule

bind hall_sensor_frame_checker_core hsfc_checker u_hsfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
